// File: design/sldf_pkg.sv
// Shared types, constants and codes of the sync and length packet deframer.
package sldf_pkg;

  localparam int unsigned DefaultMaxPacket = 1048576;
  localparam int unsigned MaxLengthW       = 21;
  localparam int unsigned PositionW        = 20;
  localparam int unsigned LengthW          = 32;
  localparam int unsigned CountW           = 21;
  localparam int unsigned HeaderCountW     = 4;

  localparam logic [7:0]              SyncByte       = 8'h5A;
  localparam logic [LengthW-1:0]      HeaderBytes    = 32'd8;
  localparam logic [HeaderCountW-1:0] SyncBytes      = 4'd4;
  localparam logic [HeaderCountW-1:0] LastHeaderByte = 4'd7;
  localparam logic [HeaderCountW-1:0] PayloadPhase   = 4'd8;
  localparam logic [MaxLengthW-1:0]   MaxLengthReset = 21'd1048576;

  typedef enum logic [2:0] {
    ST_HEADER   = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_SYNC_ERR = 3'd2,
    ST_RESET    = 3'd3,
    ST_OVERSIZE = 3'd4,
    ST_SHORT    = 3'd5
  } status_t;

  typedef enum logic {
    CFG_MAX_LENGTH        = 1'b0,
    CFG_LENGTH_BIG_ENDIAN = 1'b1
  } cfg_index_t;

  typedef struct packed {
    status_t                 status;
    logic [7:0]              out_byte;
    logic [PositionW-1:0]    position;
    logic                    packet_done;
    logic [MaxLengthW-1:0]   packet_length;
  } result_t;

endpackage

// File: design/sldf_in_if.sv
// Receive channel carrying one byte per word.
interface sldf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/sldf_out_if.sv
// Result channel carrying one classified byte per word.
interface sldf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [19:0] position;
  logic        packet_done;
  logic [20:0] packet_length;

  modport source (output valid, output status, output out_byte, output position,
                  output packet_done, output packet_length, input ready);
  modport sink (input valid, input status, input out_byte, input position,
                input packet_done, input packet_length, output ready);
endinterface

// File: design/sldf_parser.sv
// Framing state and per-byte classification logic of the deframer.
module sldf_parser #(
  parameter int unsigned MAX_PACKET = sldf_pkg::DefaultMaxPacket
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [7:0]                        byte_in,
  input  logic [sldf_pkg::MaxLengthW-1:0]   max_length,
  input  logic                              length_big_endian,
  output sldf_pkg::result_t                 res
);

  localparam logic [sldf_pkg::LengthW-1:0] PacketCap = sldf_pkg::LengthW'(MAX_PACKET);

  logic [sldf_pkg::HeaderCountW-1:0] header_count, header_count_next;
  logic [sldf_pkg::LengthW-1:0]      length_reg, length_reg_next;
  logic [sldf_pkg::CountW-1:0]       byte_count, byte_count_next;

  logic [sldf_pkg::LengthW-1:0] limit;
  logic [sldf_pkg::LengthW-1:0] max_ext;
  logic [sldf_pkg::LengthW-1:0] length_asm;
  logic [sldf_pkg::CountW-1:0]  count_inc;

  assign max_ext = sldf_pkg::LengthW'(max_length);
  assign limit   = (max_ext < PacketCap) ? max_ext : PacketCap;

  always_comb begin
    header_count_next = header_count;
    length_reg_next   = length_reg;
    byte_count_next   = byte_count;
    length_asm        = length_reg;
    count_inc         = byte_count + 1'b1;
    res.status        = sldf_pkg::ST_HEADER;
    res.out_byte      = byte_in;
    res.position      = sldf_pkg::PositionW'(header_count);
    res.packet_done   = 1'b0;
    res.packet_length = '0;

    if (header_count < sldf_pkg::SyncBytes) begin
      if (byte_in == sldf_pkg::SyncByte) begin
        header_count_next = header_count + 1'b1;
      end else begin
        header_count_next = '0;
        byte_count_next   = '0;
        res.status        = sldf_pkg::ST_SYNC_ERR;
      end
    end else if (header_count < sldf_pkg::PayloadPhase) begin
      if (length_big_endian) begin
        length_asm = {length_reg[23:0], byte_in};
      end else begin
        length_asm[8*header_count[1:0] +: 8] = byte_in;
      end
      length_reg_next   = length_asm;
      header_count_next = header_count + 1'b1;
      if (header_count == sldf_pkg::LastHeaderByte) begin
        priority if (length_asm == '0) begin
          header_count_next = '0;
          byte_count_next   = '0;
          res.status        = sldf_pkg::ST_RESET;
        end else if (length_asm[sldf_pkg::LengthW-1] || length_asm > limit) begin
          header_count_next = '0;
          byte_count_next   = '0;
          res.status        = sldf_pkg::ST_OVERSIZE;
        end else if (length_asm < sldf_pkg::HeaderBytes) begin
          header_count_next = '0;
          byte_count_next   = '0;
          res.status        = sldf_pkg::ST_SHORT;
        end else if (length_asm == sldf_pkg::HeaderBytes) begin
          header_count_next = '0;
          byte_count_next   = '0;
          res.packet_done   = 1'b1;
          res.packet_length = sldf_pkg::MaxLengthW'(sldf_pkg::HeaderBytes);
        end else begin
          byte_count_next   = sldf_pkg::CountW'(sldf_pkg::HeaderBytes);
          res.packet_length = length_asm[sldf_pkg::MaxLengthW-1:0];
        end
      end
    end else begin
      res.status        = sldf_pkg::ST_PAYLOAD;
      res.position      = byte_count[sldf_pkg::PositionW-1:0];
      res.packet_length = length_reg[sldf_pkg::MaxLengthW-1:0];
      byte_count_next   = count_inc;
      if (sldf_pkg::LengthW'(count_inc) >= length_reg) begin
        header_count_next = '0;
        byte_count_next   = '0;
        res.packet_done   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      length_reg   <= '0;
      byte_count   <= '0;
    end else if (advance) begin
      header_count <= header_count_next;
      length_reg   <= length_reg_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule

// File: design/sync_length_packet_deframer.sv
// Top level of the sync and length packet deframer.
//
//   channel | direction | word contents
//   rx      | in        | rx_byte
//   tx      | out       | status, out_byte, position, packet_done, packet_length
//
// Each word passes an input register and a result register; one word per cycle is
// sustained while tx takes each result. Synchronous reset empties both registers,
// restarts the sync hunt and restores the configuration defaults. A stall on tx
// holds the result; rx keeps accepting until the input register is also full.
module sync_length_packet_deframer #(
  parameter int unsigned MAX_PACKET = sldf_pkg::DefaultMaxPacket
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [sldf_pkg::MaxLengthW-1:0] cfg_data,
  sldf_in_if.sink                         rx,
  sldf_out_if.source                      tx
);

  logic [sldf_pkg::MaxLengthW-1:0] max_length;
  logic                            length_big_endian;

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_valid;
  sldf_pkg::result_t out_res;
  sldf_pkg::result_t res;
  logic              advance;

  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length        <= sldf_pkg::MaxLengthReset;
      length_big_endian <= 1'b1;
    end else if (cfg_we) begin
      unique case (sldf_pkg::cfg_index_t'(cfg_index))
        sldf_pkg::CFG_MAX_LENGTH:        max_length        <= cfg_data;
        sldf_pkg::CFG_LENGTH_BIG_ENDIAN: length_big_endian <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  sldf_parser #(
    .MAX_PACKET(MAX_PACKET)
  ) u_parser (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .byte_in           (in_byte),
    .max_length        (max_length),
    .length_big_endian (length_big_endian),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.status        = out_res.status;
  assign tx.out_byte      = out_res.out_byte;
  assign tx.position      = out_res.position;
  assign tx.packet_done   = out_res.packet_done;
  assign tx.packet_length = out_res.packet_length;

endmodule

// File: design/sldf_checker.sv
// Port-level checks of the deframer and their attachment to the top level.
module sldf_checker (
  input logic        clk,
  input logic        rst,
  input logic        tx_valid,
  input logic        tx_ready,
  input logic [2:0]  tx_status,
  input logic [7:0]  tx_out_byte,
  input logic [19:0] tx_position,
  input logic        tx_packet_done,
  input logic [20:0] tx_packet_length
);

  logic tx_error;

  assign tx_error = (tx_status == sldf_pkg::ST_SYNC_ERR) || (tx_status == sldf_pkg::ST_RESET)
                 || (tx_status == sldf_pkg::ST_OVERSIZE) || (tx_status == sldf_pkg::ST_SHORT);

  // A word held back by the sink stays on the channel unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_status) && $stable(tx_out_byte)
      && $stable(tx_position) && $stable(tx_packet_done) && $stable(tx_packet_length))
    else $error("result word changed while stalled");

  // Error words never complete a packet and never carry a length.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_error |-> !tx_packet_done && tx_packet_length == '0)
    else $error("error word carries packet data");

  // A sync mismatch can only occur in the first four header bytes.
  a_sync_pos: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_status == sldf_pkg::ST_SYNC_ERR |-> tx_position < 20'd4)
    else $error("sync mismatch outside the sync bytes");

  // A completed packet always carries at least the header length.
  a_done_length: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_packet_done |-> tx_packet_length >= 21'd8
      && (tx_status == sldf_pkg::ST_HEADER || tx_status == sldf_pkg::ST_PAYLOAD))
    else $error("packet completed with invalid length or status");

endmodule

bind sync_length_packet_deframer sldf_checker u_sldf_checker (
  .clk              (clk),
  .rst              (rst),
  .tx_valid         (tx.valid),
  .tx_ready         (tx.ready),
  .tx_status        (tx.status),
  .tx_out_byte      (tx.out_byte),
  .tx_position      (tx.position),
  .tx_packet_done   (tx.packet_done),
  .tx_packet_length (tx.packet_length)
);
